// File: sv/lggc_pkg.sv
// lggc_pkg: shared types and constants for the lidar grid ground classifier
// used by lidar_grid_ground_classifier and lggc_checker, no dependencies
`default_nettype none

package lggc_pkg;

  // default grid size in cells
  localparam int unsigned GridColsDef = 512;
  localparam int unsigned GridRowsDef = 512;

  // item command codes, code 3 is ignored
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // cell class codes
  typedef enum logic [1:0] {
    CLASS_NONE     = 2'd0,
    CLASS_GROUND   = 2'd1,
    CLASS_OBSTACLE = 2'd2
  } class_e;

  // configuration register indexes (word address bits)
  localparam logic [1:0] REG_EMPTY_THR = 2'd0;
  localparam logic [1:0] REG_GROUND_H  = 2'd1;
  localparam logic [1:0] REG_SPAN_THR  = 2'd2;

  // configuration reset values
  localparam logic [15:0]        EmptyThrRst = 16'd5;
  localparam logic signed [15:0] GroundHRst  = 16'sd0;
  localparam logic [15:0]        SpanThrRst  = 16'd20;

  // region limits in centimetres
  localparam logic signed [15:0] XLimit  = 16'sd4000;
  localparam logic signed [15:0] YLimit  = 16'sd3000;
  localparam logic signed [15:0] EgoX    = 16'sd150;
  localparam logic signed [15:0] EgoYHi  = 16'sd400;
  localparam logic signed [15:0] EgoYLo  = -16'sd50;

  // grid origin shift and the lowest shifted x that still truncates to col 0
  localparam logic signed [16:0] XShift   = 17'sd3000;
  localparam logic signed [16:0] YBase    = 17'sd4000;
  localparam logic signed [16:0] XKeepMin = -17'sd19;

  // floor(n / 20) = (n * 3277) >> 16, exact for n below 8192
  localparam logic [11:0] Recip20   = 12'd3277;
  localparam int unsigned RecipShift = 16;

  // one grid cell as held in the cell memory
  typedef struct packed {
    logic [15:0] min_z;
    logic [15:0] max_z;
    logic [15:0] count;
  } cell_t;

  localparam cell_t CellEmpty = '{min_z: 16'h7FFF, max_z: 16'h8000, count: 16'd0};

endpackage

`default_nettype wire

// File: sv/lidar_grid_ground_classifier.sv
// lidar_grid_ground_classifier: bins lidar points into a cell grid and classifies cells
// depends on lggc_pkg; one cell memory with a registered read port
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid_i/in_ready_o | command, point x/y/z, query col/row
//  out     | output    | out_valid_o/out_ready_i | cell class, count, min z, max z
//  cfg     | input     | psel/penable/pready  | paddr, pwdata, prdata (APB style)
//
// add, query and ignored commands each go through accept, memory read,
// then the read-modify-write or the result load, overlapped with the next accept.
// no item is accepted while the cell memory read is in progress.
// clear and reset run a sweep over all GRID_COLS*GRID_ROWS cells, one cell a cycle,
// with no item accepted; configuration writes are taken throughout.
// a query waits in its write-back cycle while a previous result is not yet taken.
`default_nettype none

module lidar_grid_ground_classifier
  import lggc_pkg::*;
#(
  parameter int unsigned GRID_COLS = GridColsDef,
  parameter int unsigned GRID_ROWS = GridRowsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         command_i,
  input  wire logic signed [15:0] point_x_i,
  input  wire logic signed [15:0] point_y_i,
  input  wire logic signed [15:0] point_z_i,
  input  wire logic [8:0]         query_col_i,
  input  wire logic [8:0]         query_row_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              cell_class_o,
  output logic [15:0]             cell_count_o,
  output logic signed [15:0]      cell_min_z_o,
  output logic signed [15:0]      cell_max_z_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned Cells = GRID_COLS * GRID_ROWS;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned ColW  = $clog2(GRID_COLS);
  localparam int unsigned RowW  = $clog2(GRID_ROWS);
  localparam int unsigned ProdW = 13 + 12;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_UPD
  } state_e;

  // configuration registers
  logic [15:0]        empty_thr_q;
  logic signed [15:0] ground_h_q;
  logic [15:0]        span_thr_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_thr_q <= EmptyThrRst;
      ground_h_q  <= GroundHRst;
      span_thr_q  <= SpanThrRst;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_EMPTY_THR: empty_thr_q <= pwdata[15:0];
        REG_GROUND_H:  ground_h_q  <= $signed(pwdata[15:0]);
        REG_SPAN_THR:  span_thr_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_EMPTY_THR: prdata = {16'd0, empty_thr_q};
      REG_GROUND_H:  prdata = {{16{ground_h_q[15]}}, ground_h_q};
      REG_SPAN_THR:  prdata = {16'd0, span_thr_q};
      default:       prdata = 32'd0;
    endcase
  end

  // point filter: outer box and ego box
  logic               in_box;
  logic               in_ego;
  logic signed [16:0] x_shift;
  logic signed [16:0] y_shift;
  logic               x_keep;
  logic [12:0]        x_mag;
  logic [12:0]        y_mag;
  logic [ProdW-1:0]   x_prod;
  logic [ProdW-1:0]   y_prod;
  logic [8:0]         pt_col;
  logic [8:0]         pt_row;
  logic [8:0]         sel_col;
  logic [8:0]         sel_row;
  logic               in_grid;
  logic               is_add;
  logic               is_query;
  logic               hit_in;

  assign in_box = (point_x_i <= XLimit) && (point_x_i >= -XLimit) &&
                  (point_y_i <= YLimit) && (point_y_i >= -YLimit);
  assign in_ego = (point_x_i < EgoX) && (point_x_i > -EgoX) &&
                  (point_y_i < EgoYHi) && (point_y_i > EgoYLo);

  // shift into grid frame, small negative x truncates to column zero
  assign x_shift = 17'(point_x_i) + XShift;
  assign y_shift = YBase - 17'(point_y_i);
  assign x_keep  = (x_shift >= XKeepMin);
  assign x_mag   = x_shift[16] ? 13'd0 : x_shift[12:0];
  assign y_mag   = y_shift[12:0];

  // divide by the cell size through the reciprocal
  assign x_prod = ProdW'(x_mag) * ProdW'(Recip20);
  assign y_prod = ProdW'(y_mag) * ProdW'(Recip20);
  assign pt_col = x_prod[RecipShift+8:RecipShift];
  assign pt_row = y_prod[RecipShift+8:RecipShift];

  assign is_add   = (command_i == CMD_ADD);
  assign is_query = (command_i == CMD_QUERY);
  assign sel_col  = is_query ? query_col_i : pt_col;
  assign sel_row  = is_query ? query_row_i : pt_row;
  assign in_grid  = (32'(sel_col) < GRID_COLS) && (32'(sel_row) < GRID_ROWS);
  assign hit_in   = in_grid && (is_query || (is_add && in_box && !in_ego && x_keep));

  // control state and result registers
  state_e             state_q, state_d;
  logic [AddrW-1:0]   sweep_q, sweep_d;
  logic               out_valid_q, out_valid_d;
  class_e             out_class_q, out_class_d;
  cell_t              out_cell_q, out_cell_d;

  // item registers, taken at accept and at address issue
  logic [1:0]         cmd_q;
  logic               hit_q;
  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic signed [15:0] z_q;
  logic [AddrW-1:0]   addr_q;

  // cell memory ports
  cell_t              mem [Cells];
  cell_t              rdata_q;
  logic               mem_re;
  logic [AddrW-1:0]   mem_raddr;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  cell_t              mem_wdata;

  logic               upd_go;
  logic               in_acc;

  // a query waits here until the result register is free
  assign upd_go = !((cmd_q == CMD_QUERY) && out_valid_q && !out_ready_i);

  always_comb begin
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_UPD:  in_ready_o = upd_go;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  // cell update for an added point
  logic signed [15:0] rd_min;
  logic signed [15:0] rd_max;
  cell_t              upd_cell;

  assign rd_min = $signed(rdata_q.min_z);
  assign rd_max = $signed(rdata_q.max_z);

  always_comb begin
    upd_cell.min_z = (z_q < rd_min) ? z_q : rd_min;
    upd_cell.max_z = (z_q > rd_max) ? z_q : rd_max;
    upd_cell.count = (rdata_q.count == 16'hFFFF) ? rdata_q.count : rdata_q.count + 16'd1;
  end

  // classification of the queried cell
  cell_t              q_cell;
  logic signed [15:0] q_min;
  logic signed [15:0] q_max;
  logic signed [16:0] q_span;
  class_e             q_class;

  assign q_cell = hit_q ? rdata_q : CellEmpty;
  assign q_min  = $signed(q_cell.min_z);
  assign q_max  = $signed(q_cell.max_z);
  assign q_span = 17'(q_max) - 17'(q_min);

  always_comb begin
    if ((q_cell.count == 16'd0) || (q_cell.count < empty_thr_q)) begin
      q_class = CLASS_NONE;
    end else if ((q_min < ground_h_q) && (q_span < $signed({1'b0, span_thr_q}))) begin
      q_class = CLASS_GROUND;
    end else begin
      q_class = CLASS_OBSTACLE;
    end
  end

  // sequencer: sweep, accept, read, write back
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_class_d = out_class_q;
    out_cell_d  = out_cell_q;
    mem_re      = 1'b0;
    mem_raddr   = AddrW'(AddrW'(col_q) * AddrW'(GRID_ROWS)) + AddrW'(row_q);
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = upd_cell;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = CellEmpty;
        sweep_d   = sweep_q + AddrW'(1);
        if (sweep_q == AddrW'(Cells - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (command_i == CMD_CLEAR) ? ST_CLEAR : ST_ADDR;
        end
      end
      ST_ADDR: begin
        mem_re  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          mem_we = (cmd_q == CMD_ADD) && hit_q;
          if (cmd_q == CMD_QUERY) begin
            out_valid_d = 1'b1;
            out_class_d = q_class;
            out_cell_d  = q_cell;
          end
          if (in_acc) begin
            state_d = (command_i == CMD_CLEAR) ? ST_CLEAR : ST_ADDR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      out_class_q <= CLASS_NONE;
      out_cell_q  <= CellEmpty;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      out_class_q <= out_class_d;
      out_cell_q  <= out_cell_d;
    end
  end

  // item fields at accept, cell address at read issue
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      hit_q <= hit_in;
      col_q <= ColW'(sel_col);
      row_q <= RowW'(sel_row);
      z_q   <= point_z_i;
    end
    if (mem_re) begin
      addr_q <= mem_raddr;
    end
  end

  // cell memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_class_o = out_class_q;
  assign cell_count_o = out_cell_q.count;
  assign cell_min_z_o = $signed(out_cell_q.min_z);
  assign cell_max_z_o = $signed(out_cell_q.max_z);

endmodule

`default_nettype wire

// File: sv/lggc_checker.sv
// lggc_checker: port-level assertions for lidar_grid_ground_classifier
// depends on lggc_pkg; bound to the top level at the end of this file
`default_nettype none

module lggc_checker
  import lggc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic [1:0]         command_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [1:0]         cell_class_i,
  input wire logic [15:0]        cell_count_i,
  input wire logic signed [15:0] cell_min_z_i,
  input wire logic signed [15:0] cell_max_z_i
);

  // a waiting result holds its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({cell_class_i, cell_count_i, cell_min_z_i, cell_max_z_i}))
    else $error("result item changed while stalled");

  // a fresh result only follows an accepted query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && command_i == CMD_QUERY, 3))
    else $error("result item without a query");

  // a classified cell has seen points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cell_class_i != CLASS_NONE |-> cell_count_i != 16'd0 &&
      cell_max_z_i >= cell_min_z_i)
    else $error("classified cell with no points");

  // a clear holds off input while the sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && command_i == CMD_CLEAR |=> !in_ready_i)
    else $error("item accepted during clear sweep");

endmodule

bind lidar_grid_ground_classifier lggc_checker u_lggc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_i   (in_ready_o),
  .command_i    (command_i),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .cell_class_i (cell_class_o),
  .cell_count_i (cell_count_o),
  .cell_min_z_i (cell_min_z_o),
  .cell_max_z_i (cell_max_z_o)
);

`default_nettype wire

// File: tb/lidar_grid_ground_classifier_tb.sv
// lidar_grid_ground_classifier_tb: self-checking bench for the lidar grid ground classifier
// directed table, then random phases under several register settings, all checked against
// a cell statistics predictor; depends on lggc_pkg and lidar_grid_ground_classifier
`timescale 1ns / 1ps

module lidar_grid_ground_classifier_tb
  import lggc_pkg::*;
();

  localparam int GridCols = 512;
  localparam int GridRows = 512;
  localparam int CellCm = 20;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned DrainCycles = 8;
  localparam longint unsigned CycleLimit = 8_000_000;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned NumHot = 16;
  localparam int unsigned LongHold = 150;

  typedef enum int unsigned {
    RX_FREE,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [8:0]         col;
    logic [8:0]         row;
  } grid_item_t;

  typedef struct {
    logic [1:0]         cls;
    logic [15:0]        cnt;
    logic signed [15:0] min_z;
    logic signed [15:0] max_z;
  } cell_result_t;

  typedef struct {
    grid_item_t   item;
    int unsigned  reps;
    bit           typed;
    cell_result_t res;
  } stim_row_t;

  // clock and reset
  logic clk_i;
  logic rst_ni;

  // item input side
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         command;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic [8:0]         query_col;
  logic [8:0]         query_row;

  // result side
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         cell_class;
  logic [15:0]        cell_count;
  logic signed [15:0] cell_min_z;
  logic signed [15:0] cell_max_z;

  // register port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: cells never written since the last clear read as empty
  cell_t              grid_cells[int];
  logic [15:0]        cfg_empty_thr;
  logic signed [15:0] cfg_ground_h;
  logic [15:0]        cfg_span_thr;
  cell_result_t       cell_expect_q[$];

  stim_row_t   directed_rows[$];
  int          hot_col[NumHot];
  int          hot_row[NumHot];
  int unsigned burst_left;
  bit          rx_hold_req;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned clears_sent;
  int unsigned mismatches;

  lidar_grid_ground_classifier u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .point_z_i    (point_z),
    .query_col_i  (query_col),
    .query_row_i  (query_row),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .cell_class_o (cell_class),
    .cell_count_o (cell_count),
    .cell_min_z_o (cell_min_z),
    .cell_max_z_o (cell_max_z),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // grid predictor: applies one item, returns the query result if any
  function automatic void grid_predict(input grid_item_t it, output bit has_res,
                                       output cell_result_t res);
    int    px, py, pz, col, row, key, span;
    bit    keep;
    cell_t c;
    has_res   = 1'b0;
    res.cls   = CLASS_NONE;
    res.cnt   = 16'd0;
    res.min_z = 16'sh7FFF;
    res.max_z = 16'sh8000;
    px = it.x;
    py = it.y;
    pz = it.z;
    case (it.cmd)
      CMD_CLEAR: grid_cells.delete();
      CMD_ADD: begin
        col  = (px + int'(XShift)) / CellCm;
        row  = (int'(YBase) - py) / CellCm;
        keep = 1'b1;
        // outside the region of interest
        if (px > int'(XLimit) || px < -int'(XLimit) || py > int'(YLimit) || py < -int'(YLimit))
          keep = 1'b0;
        // ego box around the vehicle
        if (px < int'(EgoX) && px > -int'(EgoX) && py < int'(EgoYHi) && py > int'(EgoYLo))
          keep = 1'b0;
        if (col < 0 || col >= GridCols || row < 0 || row >= GridRows)
          keep = 1'b0;
        if (keep) begin
          key = col * GridRows + row;
          c   = grid_cells.exists(key) ? grid_cells[key] : CellEmpty;
          if (pz < $signed(c.min_z)) c.min_z = it.z;
          if (pz > $signed(c.max_z)) c.max_z = it.z;
          if (c.count != 16'hFFFF) c.count = c.count + 16'd1;
          grid_cells[key] = c;
        end
      end
      CMD_QUERY: begin
        has_res = 1'b1;
        col = it.col;
        row = it.row;
        key = col * GridRows + row;
        c   = CellEmpty;
        if (col < GridCols && row < GridRows && grid_cells.exists(key)) c = grid_cells[key];
        res.cnt   = c.count;
        res.min_z = c.min_z;
        res.max_z = c.max_z;
        span = int'($signed(c.max_z)) - int'($signed(c.min_z));
        if (c.count != 16'd0 && c.count >= cfg_empty_thr) begin
          if ($signed(c.min_z) < cfg_ground_h && span < int'(cfg_span_thr))
            res.cls = CLASS_GROUND;
          else
            res.cls = CLASS_OBSTACLE;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%h (%0d), got 0x%h", $time, name, want, want, got);
      mismatches++;
    end
  endtask

  // one register access, setup then access phase
  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [15:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, wdata};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write all three registers, mirror them in the predictor, read them back
  task automatic set_config(input logic [15:0] thr, input logic signed [15:0] gh,
                            input logic [15:0] span);
    logic [31:0] rd;
    apb_access(REG_EMPTY_THR, 1'b1, thr, rd);
    apb_access(REG_GROUND_H, 1'b1, gh, rd);
    apb_access(REG_SPAN_THR, 1'b1, span, rd);
    cfg_empty_thr = thr;
    cfg_ground_h  = gh;
    cfg_span_thr  = span;
    apb_access(REG_EMPTY_THR, 1'b0, 16'h0000, rd);
    check_field("empty_threshold readback", thr, rd[15:0]);
    apb_access(REG_GROUND_H, 1'b0, 16'h0000, rd);
    check_field("ground_height readback", gh, rd[15:0]);
    apb_access(REG_SPAN_THR, 1'b0, 16'h0000, rd);
    check_field("span_threshold readback", span, rd[15:0]);
  endtask

  // offer one item, hold it until taken, then predict it
  task automatic send_item(input grid_item_t it, input bit typed, input cell_result_t typed_res);
    bit           has_res;
    cell_result_t res;
    @(negedge clk_i);
    in_valid  <= 1'b1;
    command   <= it.cmd;
    point_x   <= it.x;
    point_y   <= it.y;
    point_z   <= it.z;
    query_col <= it.col;
    query_row <= it.row;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    grid_predict(it, has_res, res);
    if (has_res) begin
      if (typed) res = typed_res;
      cell_expect_q = {cell_expect_q, res};
    end
    if (it.cmd == CMD_CLEAR) clears_sent++;
    items_sent++;
  endtask

  // bursts of random length, random gaps between them
  task automatic sender_gap();
    int unsigned idle;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      idle = $urandom_range(0, 6);
      if (idle != 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (idle - 1) @(negedge clk_i);
      end
    end
  endtask

  // stop offering and wait until every expected result is in
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (cell_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void table_row(input logic [1:0] cmd, input int x, input int y, input int z,
                                    input int col, input int row, input int unsigned reps,
                                    input bit typed, input logic [1:0] cls, input int cnt,
                                    input int mn, input int mx);
    stim_row_t r;
    r.item.cmd  = cmd;
    r.item.x    = 16'(x);
    r.item.y    = 16'(y);
    r.item.z    = 16'(z);
    r.item.col  = 9'(col);
    r.item.row  = 9'(row);
    r.reps      = reps;
    r.typed     = typed;
    r.res.cls   = cls;
    r.res.cnt   = 16'(cnt);
    r.res.min_z = 16'(mn);
    r.res.max_z = 16'(mx);
    directed_rows = {directed_rows, r};
  endfunction

  // random item, mostly points and queries aimed at a few busy cells
  function automatic grid_item_t random_grid_item();
    grid_item_t  it;
    int unsigned pick, h;
    int          off;
    it.cmd = CMD_ADD;
    it.x   = 16'($urandom());
    it.y   = 16'($urandom());
    it.col = 9'($urandom());
    it.row = 9'($urandom());
    case ($urandom_range(0, 3))
      0, 1: it.z = 16'(int'($urandom_range(0, 60)) - 40);
      2: it.z = 16'(int'($urandom_range(0, 400)) - 100);
      default: it.z = 16'($urandom());
    endcase
    pick = $urandom_range(0, 99);
    h = $urandom_range(0, NumHot - 1);
    if (pick < 50) begin
      // point inside a busy cell, column 0 also from just below the shifted origin
      off  = (hot_col[h] == 0) ? int'($urandom_range(0, 38)) - 19 : int'($urandom_range(0, 19));
      it.x = 16'(hot_col[h] * CellCm - int'(XShift) + off);
      it.y = 16'(int'(YBase) - hot_row[h] * CellCm - int'($urandom_range(0, 19)));
    end else if (pick < 62) begin
      it.cmd = CMD_ADD;
    end else if (pick < 70) begin
      it.x = 16'(int'($urandom_range(0, 8000)) - 4000);
      it.y = 16'(int'($urandom_range(0, 6000)) - 3000);
    end else if (pick < 90) begin
      it.cmd = CMD_QUERY;
      it.col = 9'(hot_col[h]);
      it.row = 9'(hot_row[h]);
    end else if (pick < 96) begin
      it.cmd = CMD_QUERY;
    end else begin
      it.cmd = CmdUnused;
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (cell_expect_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got class %0d count %0d",
                 $time, cell_class, cell_count);
        mismatches++;
      end else begin
        want = cell_expect_q.pop_front();
        check_field("cell_class", 16'(want.cls), 16'(cell_class));
        check_field("cell_count", want.cnt, cell_count);
        check_field("cell_min_z", want.min_z, cell_min_z);
        check_field("cell_max_z", want.max_z, cell_max_z);
        results_checked++;
      end
    end
  end

  // receiver: stalls on its own pattern, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned stretch_left;
    rx_mode_e    mode;
    out_ready    = 1'b0;
    hold_left    = 0;
    stretch_left = 0;
    mode         = RX_FREE;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LongHold;
      end
      if (stretch_left == 0) begin
        mode         = rx_mode_e'($urandom_range(0, 2));
        stretch_left = $urandom_range(10, 60);
      end
      stretch_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // run limit
  initial begin
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run timed out with %0d results outstanding", $time, cell_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned        ph, i, k;
    grid_item_t         it;
    cell_result_t       none;
    logic [15:0]        thr_set[NumPhases];
    logic signed [15:0] gh_set[NumPhases];
    logic [15:0]        span_set[NumPhases];
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    command     = CMD_CLEAR;
    point_x     = '0;
    point_y     = '0;
    point_z     = '0;
    query_col   = '0;
    query_row   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rx_hold_req = 1'b0;
    burst_left  = 0;
    none        = '{CLASS_NONE, 16'd0, 16'sh7FFF, 16'sh8000};
    cfg_empty_thr = EmptyThrRst;
    cfg_ground_h  = GroundHRst;
    cfg_span_thr  = SpanThrRst;
    grid_cells.delete();

    // empty grid straight after reset, both corners
    table_row(CMD_QUERY, 0, 0, 0, 0, 0, 1, 1, CLASS_NONE, 0, 32767, -32768);
    table_row(CMD_QUERY, 0, 0, 0, 511, 511, 1, 1, CLASS_NONE, 0, 32767, -32768);
    // inside the ego box, then on its edges
    table_row(CMD_ADD, 0, 100, 3, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, 149, 399, 3, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, 150, 0, 7, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, 100, -50, 8, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 157, 200, 1, 0, CLASS_NONE, 0, 0, 0);
    // region edges and field extremes
    table_row(CMD_ADD, 4001, 0, 1, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, 4000, -3000, 32767, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, -3000, 3000, -32768, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, 32767, -32768, 0, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    // shifted x just below zero still lands in column 0, one step further does not
    table_row(CMD_ADD, -3019, 0, -10, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, -3020, 0, -11, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 350, 350, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 0, 50, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 0, 200, 1, 0, CLASS_NONE, 0, 0, 0);
    // five low flat points give ground, one tall point makes it an obstacle
    table_row(CMD_ADD, 1000, 1000, -5, 0, 0, 5, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 200, 150, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_ADD, 1000, 1000, 100, 0, 0, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 200, 150, 1, 0, CLASS_NONE, 0, 0, 0);
    // unused command code leaves the cell alone
    table_row(CmdUnused, 1000, 1000, -300, 200, 150, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 200, 150, 1, 0, CLASS_NONE, 0, 0, 0);
    // clear sweep empties the grid
    table_row(CMD_CLEAR, -1, -1, -1, 511, 511, 1, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 200, 150, 1, 1, CLASS_NONE, 0, 32767, -32768);
    // many identical points in one cell
    table_row(CMD_ADD, -1000, -1000, -7, 0, 0, 40, 0, CLASS_NONE, 0, 0, 0);
    table_row(CMD_QUERY, 0, 0, 0, 100, 250, 1, 1, CLASS_GROUND, 40, -7, -7);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset register values
    foreach (directed_rows[r]) begin
      for (k = 0; k < directed_rows[r].reps; k++) begin
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);
        sender_gap();
      end
    end

    // busy cells: the one filled above, column 0 and a spread of others
    hot_col[0] = 100;
    hot_row[0] = 250;
    hot_col[1] = 0;
    hot_row[1] = 200;
    for (k = 2; k < NumHot; k++) begin
      hot_col[k] = $urandom_range(0, 350);
      hot_row[k] = $urandom_range(50, 350);
    end

    // register settings per phase, extremes included, the last one random
    thr_set  = '{16'd3, 16'd0, 16'd65535, 16'd1, 16'($urandom_range(0, 8))};
    gh_set   = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd50,
                 16'(int'($urandom_range(0, 400)) - 200)};
    span_set = '{16'd30, 16'd0, 16'd65535, 16'd65535, 16'($urandom_range(0, 300))};

    for (ph = 0; ph < NumPhases; ph++) begin
      drain();
      set_config(thr_set[ph], gh_set[ph], span_set[ph]);
      i = 0;
      if (ph == 2) begin
        // output held off while queries keep coming, so the input backs up
        rx_hold_req = 1'b1;
        for (k = 0; k < 16; k++) begin
          it     = random_grid_item();
          it.cmd = CMD_QUERY;
          it.col = 9'(hot_col[k]);
          it.row = 9'(hot_row[k]);
          send_item(it, 1'b0, none);
          i++;
        end
      end
      for (; i < PhaseItems; i++) begin
        it = random_grid_item();
        if (ph == NumPhases - 1 && i == PhaseItems / 2) it.cmd = CMD_CLEAR;
        send_item(it, 1'b0, none);
        sender_gap();
      end
    end

    drain();
    $display("covered %0d items incl. %0d clears and %0d checked results over %0d settings",
             items_sent, clears_sent, results_checked, NumPhases + 1);
    $display("thresholds and ground height at both extremes, one long output stall");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
